// ===== rtl/shac_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// SHA-256 compression package
// Shared constants, round table, initial hash values, controller state and
// the command and status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package shac_pkg;

  localparam int WORD_W       = 32;
  localparam int HASH_WORDS   = 8;
  localparam int WINDOW_DEPTH = 16;
  localparam int ROUND_COUNT  = 64;
  localparam int ROUND_IDX_W  = $clog2(ROUND_COUNT);
  localparam int ROUND_CNT_W  = $clog2(ROUND_COUNT + 1);
  localparam int POS_W        = $clog2(WINDOW_DEPTH);
  localparam int HIDX_W       = $clog2(HASH_WORDS);

  // Index of the final digest word for each variant.
  localparam logic [HIDX_W-1:0] LAST_IDX_256 = HIDX_W'(7);
  localparam logic [HIDX_W-1:0] LAST_IDX_224 = HIDX_W'(6);

  localparam logic VARIANT_224 = 1'b1;

  localparam logic [WORD_W-1:0] ROUND_K [ROUND_COUNT] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  localparam logic [WORD_W-1:0] IV_256 [HASH_WORDS] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [WORD_W-1:0] IV_224 [HASH_WORDS] = '{
    32'hc1059ed8, 32'h367cd507, 32'h3070dd17, 32'hf70e5939,
    32'hffc00b31, 32'h68581511, 32'h64f98fa7, 32'hbefa4fa4
  };

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ROUND,
    ST_FINAL,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic                   load_word;
    logic                   load_iv;
    logic                   start_block;
    logic                   round_en;
    logic                   sched_direct;
    logic [ROUND_IDX_W-1:0] round_idx;
    logic                   hash_add;
    logic                   emit_en;
    logic [HIDX_W-1:0]      emit_idx;
    logic                   emit_last;
  } cmd_t;

  typedef struct packed {
    logic variant;
    logic out_free;
  } sts_t;

endpackage
`default_nettype wire

// ===== rtl/shac_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// SHA-256 compression controller
// Counts message words, sequences the rounds, the hash update and the
// digest beats.
// ----------------------------------------------------------------------------
module shac_ctrl (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_tvalid,
  output logic               in_tready,
  input  wire logic          new_message,
  input  wire logic          end_of_message,
  input  wire shac_pkg::sts_t sts,
  output shac_pkg::cmd_t     cmd
);

  shac_pkg::state_t                    state_r, state_nxt;
  logic [shac_pkg::POS_W-1:0]          pos_r, pos_nxt;
  logic [shac_pkg::ROUND_CNT_W-1:0]    round_r, round_nxt;
  logic [shac_pkg::HIDX_W-1:0]         emit_r, emit_nxt;
  logic                                eom_r, eom_nxt;
  logic                                in_fire;
  logic                                block_done;
  logic                                last_round;
  logic [shac_pkg::HIDX_W-1:0]         last_idx;

  assign in_tready  = (state_r == shac_pkg::ST_IDLE);
  assign in_fire    = in_tvalid && in_tready;
  assign block_done = in_fire && !new_message &&
                      (pos_r == shac_pkg::POS_W'(shac_pkg::WINDOW_DEPTH - 1));
  assign last_round = (round_r == shac_pkg::ROUND_CNT_W'(shac_pkg::ROUND_COUNT - 1));
  assign last_idx   = (sts.variant == shac_pkg::VARIANT_224) ?
                      shac_pkg::LAST_IDX_224 : shac_pkg::LAST_IDX_256;

  // Next state and counters.
  always_comb begin
    state_nxt = state_r;
    pos_nxt   = pos_r;
    round_nxt = round_r;
    emit_nxt  = emit_r;
    eom_nxt   = eom_r;
    unique case (state_r)
      shac_pkg::ST_IDLE: begin
        if (in_fire) begin
          if (new_message) begin
            pos_nxt = shac_pkg::POS_W'(1);
          end else begin
            pos_nxt = pos_r + shac_pkg::POS_W'(1);
          end
          if (block_done) begin
            round_nxt = '0;
            eom_nxt   = end_of_message;
            state_nxt = shac_pkg::ST_ROUND;
          end
        end
      end
      shac_pkg::ST_ROUND: begin
        round_nxt = round_r + shac_pkg::ROUND_CNT_W'(1);
        if (last_round) begin
          state_nxt = shac_pkg::ST_FINAL;
        end
      end
      shac_pkg::ST_FINAL: begin
        emit_nxt  = '0;
        state_nxt = eom_r ? shac_pkg::ST_EMIT : shac_pkg::ST_IDLE;
      end
      shac_pkg::ST_EMIT: begin
        if (sts.out_free) begin
          emit_nxt = emit_r + shac_pkg::HIDX_W'(1);
          if (emit_r == last_idx) begin
            state_nxt = shac_pkg::ST_IDLE;
          end
        end
      end
      default: state_nxt = shac_pkg::ST_IDLE;
    endcase
  end

  // Datapath commands.
  always_comb begin
    cmd              = '0;
    cmd.round_idx    = round_r[shac_pkg::ROUND_IDX_W-1:0];
    cmd.sched_direct = (round_r < shac_pkg::ROUND_CNT_W'(shac_pkg::WINDOW_DEPTH));
    cmd.emit_idx     = emit_r;
    cmd.emit_last    = (emit_r == last_idx);
    unique case (state_r)
      shac_pkg::ST_IDLE: begin
        cmd.load_word   = in_fire;
        cmd.load_iv     = in_fire && new_message;
        cmd.start_block = block_done;
      end
      shac_pkg::ST_ROUND: cmd.round_en = 1'b1;
      shac_pkg::ST_FINAL: cmd.hash_add = 1'b1;
      shac_pkg::ST_EMIT:  cmd.emit_en  = sts.out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= shac_pkg::ST_IDLE;
      pos_r   <= '0;
      round_r <= '0;
      emit_r  <= '0;
      eom_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      pos_r   <= pos_nxt;
      round_r <= round_nxt;
      emit_r  <= emit_nxt;
      eom_r   <= eom_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/shac_dpath.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// SHA-256 compression datapath
// Schedule window shift line, working and hash registers, one round per
// cycle, configuration register and the digest output register.
// ----------------------------------------------------------------------------
module shac_dpath (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic [shac_pkg::WORD_W-1:0]   message_word,
  input  wire logic                          cfg_we,
  input  wire logic                          cfg_variant,
  input  wire shac_pkg::cmd_t                cmd,
  output shac_pkg::sts_t                     sts,
  input  wire logic                          out_ready,
  output logic                               out_valid,
  output logic [shac_pkg::WORD_W-1:0]        out_word,
  output logic                               out_last
);

  localparam int W = shac_pkg::WORD_W;

  function automatic logic [W-1:0] rotr(input logic [W-1:0] x, input int unsigned n);
    logic [2*W-1:0] d;
    d = {x, x} >> n;
    return d[W-1:0];
  endfunction

  logic [W-1:0] window_r [shac_pkg::WINDOW_DEPTH];
  logic [W-1:0] work_r   [shac_pkg::HASH_WORDS];
  logic [W-1:0] hash_r   [shac_pkg::HASH_WORDS];
  logic         variant_r;
  logic         out_valid_r;
  logic [W-1:0] out_word_r;
  logic         out_last_r;

  logic [W-1:0] wt, s0, s1, bs0, bs1, ch, maj, t1, t2;

  // Message schedule and round function.
  always_comb begin
    s0 = rotr(window_r[1], 7) ^ rotr(window_r[1], 18) ^ (window_r[1] >> 3);
    s1 = rotr(window_r[14], 17) ^ rotr(window_r[14], 19) ^ (window_r[14] >> 10);
    wt = cmd.sched_direct ? window_r[0] : (s1 + window_r[9] + s0 + window_r[0]);
    bs1 = rotr(work_r[4], 6) ^ rotr(work_r[4], 11) ^ rotr(work_r[4], 25);
    ch  = (work_r[4] & work_r[5]) ^ (~work_r[4] & work_r[6]);
    bs0 = rotr(work_r[0], 2) ^ rotr(work_r[0], 13) ^ rotr(work_r[0], 22);
    maj = (work_r[0] & work_r[1]) ^ (work_r[0] & work_r[2]) ^ (work_r[1] & work_r[2]);
    t1  = work_r[7] + bs1 + ch + shac_pkg::ROUND_K[cmd.round_idx] + wt;
    t2  = bs0 + maj;
  end

  // The window shifts by one word per loaded word and per round. The first
  // sixteen rounds rotate it, the later ones shift in the expanded word.
  always_ff @(posedge clk) begin
    if (cmd.load_word || cmd.round_en) begin
      for (int i = 0; i < shac_pkg::WINDOW_DEPTH - 1; i++) begin
        window_r[i] <= window_r[i+1];
      end
      window_r[shac_pkg::WINDOW_DEPTH-1] <= cmd.load_word ? message_word : wt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start_block) begin
      for (int i = 0; i < shac_pkg::HASH_WORDS; i++) begin
        work_r[i] <= hash_r[i];
      end
    end else if (cmd.round_en) begin
      work_r[7] <= work_r[6];
      work_r[6] <= work_r[5];
      work_r[5] <= work_r[4];
      work_r[4] <= work_r[3] + t1;
      work_r[3] <= work_r[2];
      work_r[2] <= work_r[1];
      work_r[1] <= work_r[0];
      work_r[0] <= t1 + t2;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < shac_pkg::HASH_WORDS; i++) begin
        hash_r[i] <= shac_pkg::IV_256[i];
      end
    end else if (cmd.load_iv) begin
      for (int i = 0; i < shac_pkg::HASH_WORDS; i++) begin
        hash_r[i] <= (variant_r == shac_pkg::VARIANT_224) ?
                     shac_pkg::IV_224[i] : shac_pkg::IV_256[i];
      end
    end else if (cmd.hash_add) begin
      for (int i = 0; i < shac_pkg::HASH_WORDS; i++) begin
        hash_r[i] <= hash_r[i] + work_r[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      variant_r <= 1'b0;
    end else if (cfg_we) begin
      variant_r <= cfg_variant;
    end
  end

  // Output register: takes a new digest word when empty or being drained.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit_en) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_en) begin
      out_word_r <= hash_r[cmd.emit_idx];
      out_last_r <= cmd.emit_last;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_word     = out_word_r;
  assign out_last     = out_last_r;
  assign sts.variant  = variant_r;
  assign sts.out_free = !out_valid_r || out_ready;

endmodule
`default_nettype wire

// ===== rtl/sha256_block_compression_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Sequence: the sixteenth word beat of a block starts the rounds and then the
//   hash update; for the final block the output register is loaded then, and
//   the digest beats follow one per cycle while out_tready stays high.
// Blocks: no word beat is taken while a block compresses or its digest is emitted.
// Reset (synchronous, rst_n low): hash words take the SHA-256 initial values,
//   the variant register clears to SHA-256, the schedule window is not reset.
// ----------------------------------------------------------------------------
// SHA-256 / SHA-224 block compression unit
// Streams padded message words in, compresses each 16-word block and emits
// the digest words after the final block of a message.
// ----------------------------------------------------------------------------
module sha256_block_compression_unit (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // Message word beats.
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [31:0] in_tdata,   // [31:0] message_word
  input  wire logic [0:0]  in_tuser,   // [0] new_message
  input  wire logic        in_tlast,   // end_of_message
  // Digest word beats.
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [31:0]      out_tdata,  // [31:0] digest_word
  output logic             out_tlast,  // last_digest_word
  // Configuration: digest_variant, 0 = SHA-256, 1 = SHA-224.
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [0:0]  cfg_data
);

  shac_pkg::cmd_t cmd;
  shac_pkg::sts_t sts;

  // The variant register takes a write at any time; the user writes it only
  // while no message is in flight.
  assign cfg_ready = 1'b1;

  // The controller owns every counter (word position, round index, digest
  // index); the datapath owns all words and the output register.
  shac_ctrl u_ctrl (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_tvalid      (in_tvalid),
    .in_tready      (in_tready),
    .new_message    (in_tuser[0]),
    .end_of_message (in_tlast),
    .sts            (sts),
    .cmd            (cmd)
  );

  shac_dpath u_dpath (
    .clk          (clk),
    .rst_n        (rst_n),
    .message_word (in_tdata),
    .cfg_we       (cfg_valid),
    .cfg_variant  (cfg_data[0]),
    .cmd          (cmd),
    .sts          (sts),
    .out_ready    (out_tready),
    .out_valid    (out_tvalid),
    .out_word     (out_tdata),
    .out_last     (out_tlast)
  );

`ifndef SYNTHESIS
  // No new message word is taken while rounds are running.
  a_no_accept_in_rounds: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready |-> !cmd.round_en)
    else $error("input ready while rounds run");

  // A digest word is never loaded over one that has not been taken.
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit_en |-> (!out_tvalid || out_tready))
    else $error("digest word overwritten");

  // After the final digest beat no further beat follows at once.
  a_digest_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tready && out_tlast) |=> !out_tvalid)
    else $error("digest beat after final word");
`endif

endmodule
`default_nettype wire
